>>> rtl/u16u8_pkg.sv
// Shared types, constants and the UTF-8 byte encoder for the UTF-16 to UTF-8 transcoder.
// No dependencies.
package u16u8_pkg;

    localparam int JOB_DEPTH_DEFAULT = 2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ODD        = 3'd1;
    localparam logic [2:0] ST_LONE_LOW   = 3'd2;
    localparam logic [2:0] ST_BAD_PAIR   = 3'd3;
    localparam logic [2:0] ST_TRUNC_HIGH = 3'd4;

    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // One transfer worth of work for the back end: up to four UTF-8 bytes of
    // one code point, optionally followed by the closing status item.
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  nbytes;
        logic        has_status;
        logic [2:0]  status;
    } job_t;

    // Byte k of the UTF-8 encoding of cp, which is nb bytes long.
    function automatic logic [7:0] utf8_enc(input logic [20:0] cp, input logic [2:0] nb,
                                            input logic [2:0] k);
        logic [7:0] b;
        b = 8'h00;
        case (nb)
            3'd1: b = {1'b0, cp[6:0]};
            3'd2:
            begin
                case (k)
                    3'd0:    b = {3'b110, cp[10:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd3:
            begin
                case (k)
                    3'd0:    b = {4'b1110, cp[15:12]};
                    3'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd4:
            begin
                case (k)
                    3'd0:    b = {5'b11110, cp[20:18]};
                    3'd1:    b = {2'b10, cp[17:12]};
                    3'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/u16u8_front.sv
// Front end: pairs input bytes into code units, joins surrogates and tracks errors.
// Depends on u16u8_pkg; produces one job per input byte that causes results.
module u16u8_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output logic              job_push,
    output u16u8_pkg::job_t   job
);
    import u16u8_pkg::*;

    logic       order_big_reg;
    logic       half_reg, half_next;
    logic [7:0] held_reg, held_next;
    logic       hsw_reg, hsw_next;
    logic [9:0] hbits_reg, hbits_next;
    logic [2:0] err_reg, err_next;
    logic [15:0] unit;
    logic        is_high;
    logic        is_low;

    assign unit = order_big_reg ? {held_reg, data_byte} : {data_byte, held_reg};
    assign is_high = (unit[15:10] == 6'b110110);
    assign is_low  = (unit[15:10] == 6'b110111);

    always_comb
    begin
        half_next  = half_reg;
        held_next  = held_reg;
        hsw_next   = hsw_reg;
        hbits_next = hbits_reg;
        err_next   = err_reg;
        job        = '0;
        if (err_reg == ST_OK)
        begin
            if (!half_reg)
            begin
                half_next = 1'b1;
                held_next = data_byte;
                if (final_byte)
                begin
                    err_next = ST_ODD;
                end
            end
            else
            begin
                half_next = 1'b0;
                if (hsw_reg)
                begin
                    hsw_next = 1'b0;
                    if (is_low)
                    begin
                        job.cp     = SUPP_BASE + {1'b0, hbits_reg, unit[9:0]};
                        job.nbytes = 3'd4;
                    end
                    else
                    begin
                        err_next = ST_BAD_PAIR;
                    end
                end
                else if (is_high)
                begin
                    hsw_next   = 1'b1;
                    hbits_next = unit[9:0];
                end
                else if (is_low)
                begin
                    err_next = ST_LONE_LOW;
                end
                else
                begin
                    job.cp = {5'd0, unit};
                    if (unit[15:7] == 9'd0)
                    begin
                        job.nbytes = 3'd1;
                    end
                    else if (unit[15:11] == 5'd0)
                    begin
                        job.nbytes = 3'd2;
                    end
                    else
                    begin
                        job.nbytes = 3'd3;
                    end
                end
                if (final_byte && (err_next == ST_OK) && hsw_next)
                begin
                    err_next = ST_TRUNC_HIGH;
                end
            end
        end
        if (final_byte)
        begin
            job.has_status = 1'b1;
            job.status     = err_next;
            half_next      = 1'b0;
            held_next      = 8'h00;
            hsw_next       = 1'b0;
            hbits_next     = 10'd0;
            err_next       = ST_OK;
        end
    end

    assign job_push = accept && ((job.nbytes != 3'd0) || job.has_status);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_big_reg <= 1'b0;
            half_reg      <= 1'b0;
            held_reg      <= 8'h00;
            hsw_reg       <= 1'b0;
            hbits_reg     <= 10'd0;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                order_big_reg <= cfg_data;
            end
            if (accept)
            begin
                half_reg  <= half_next;
                held_reg  <= held_next;
                hsw_reg   <= hsw_next;
                hbits_reg <= hbits_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

>>> rtl/u16u8_job_fifo.sv
// Short job queue between the front and back ends.
// Depends on u16u8_pkg for the job type.
module u16u8_job_fifo #(
    parameter int Depth = u16u8_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u16u8_pkg::job_t   wdata,
    input  logic              pop,
    output u16u8_pkg::job_t   rdata,
    output logic              full,
    output logic              empty
);
    import u16u8_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    job_t            mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/u16u8_back.sv
// Back end: expands each job into UTF-8 bytes and any status item, one per cycle,
// into an output register whenever it is empty or popped. Depends on u16u8_pkg.
module u16u8_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_avail,
    input  u16u8_pkg::job_t   job_in,
    output logic              job_take,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        utf8_byte,
    output logic              byte_present,
    output logic              run_end,
    output logic              message_done,
    output logic [2:0]        status
);
    import u16u8_pkg::*;

    job_t       cur_reg;
    logic       cur_valid_reg;
    logic [2:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       present_reg;
    logic       end_reg;
    logic       done_reg;
    logic [2:0] status_reg;

    logic [2:0] total;
    logic       out_free;
    logic       emit;
    logic       last;
    logic       is_data;

    assign total    = cur_reg.nbytes + {2'b00, cur_reg.has_status};
    assign out_free = !out_valid_reg || pop;
    assign emit     = cur_valid_reg && out_free;
    assign last     = (idx_reg == total - 3'd1);
    assign is_data  = (idx_reg < cur_reg.nbytes);
    assign job_take = job_avail && (!cur_valid_reg || (emit && last));

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            cur_reg <= job_in;
        end
        if (emit)
        begin
            byte_reg    <= is_data ? utf8_enc(cur_reg.cp, cur_reg.nbytes, idx_reg) : 8'h00;
            present_reg <= is_data;
            end_reg     <= last;
            done_reg    <= !is_data;
            status_reg  <= is_data ? ST_OK : cur_reg.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_take)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 3'd0;
            end
            else if (emit)
            begin
                if (last)
                begin
                    cur_valid_reg <= 1'b0;
                    idx_reg       <= 3'd0;
                end
                else
                begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign utf8_byte    = byte_reg;
    assign byte_present = present_reg;
    assign run_end      = end_reg;
    assign message_done = done_reg;
    assign status       = status_reg;

endmodule

>>> rtl/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder.
// Depends on u16u8_pkg, u16u8_front, u16u8_job_fifo and u16u8_back.

// The transcoder takes a UTF-16 message one byte per transfer and returns
// UTF-8 bytes, one per transfer, followed by one status item when the byte
// flagged as final arrives. The front end accepts a byte in every cycle in
// which the job queue has room (full low): it pairs bytes into code units in
// the configured byte order, joins surrogate pairs, tracks the first error of
// the message and queues one job for each byte that causes results. The back
// end drains one job item per cycle into the output register whenever the
// register is empty or popped, so the output port carries at most one item
// per cycle, and a pop in the same cycle as a new item is loaded keeps it
// streaming without gaps. The sustained input rate is therefore set by the
// output port and by how many result items each byte pair yields; a
// three-byte code point whose pair also closes the message with its status
// item is the worst case. ASCII text runs at the input limit of one byte
// per cycle while the receiver keeps up. The queue depth (JobDepth) sets
// how many jobs the front end may run ahead.
// An accepted byte's first result passes the queue, the current job register
// and the output register. After an error inside a message no data bytes are
// produced until the final byte, which yields the status item with the
// first error seen; the byte order register is written over its own
// transfer channel and must only change while the block is idle.
module utf16_to_utf8_transcoder #(
    parameter int JobDepth = u16u8_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] utf8_byte,
    output logic       byte_present,
    output logic       run_end,
    output logic       message_done,
    output logic [2:0] status
);
    import u16u8_pkg::*;

    job_t front_job;
    job_t head_job;
    logic job_push;
    logic job_take;
    logic fifo_full;
    logic fifo_empty;
    logic accept;

    // Always writable; the user must write the register only while idle.
    assign cfg_ready = 1'b1;
    assign full      = fifo_full;
    assign accept    = push && !fifo_full;

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .job_push   (job_push),
        .job        (front_job)
    );

    u16u8_job_fifo #(
        .Depth (JobDepth)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (front_job),
        .pop   (job_take),
        .rdata (head_job),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    u16u8_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_avail    (!fifo_empty),
        .job_in       (head_job),
        .job_take     (job_take),
        .pop          (pop),
        .empty        (empty),
        .utf8_byte    (utf8_byte),
        .byte_present (byte_present),
        .run_end      (run_end),
        .message_done (message_done),
        .status       (status)
    );

endmodule

>>> dv/tb_utf16_to_utf8_transcoder.sv
// Self-checking testbench for utf16_to_utf8_transcoder: UTF-16 byte streams in, UTF-8 out.
// Depends on u16u8_pkg and the transcoder RTL; it needs no other file.
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder;

    import u16u8_pkg::*;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 40;

    // One byte of a UTF-16 message, as the sender hands it over.
    typedef struct packed {
        logic [7:0] octet;
        logic       last;
    } utf16_octet_t;

    // One result item of the transcoder.
    typedef struct packed {
        logic [7:0] octet;
        logic       present;
        logic       last_of_run;
        logic       done;
        logic [2:0] code;
    } utf8_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] data_byte = 8'h00;
    logic       final_byte = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] utf8_byte;
    logic       byte_present;
    logic       run_end;
    logic       message_done;
    logic [2:0] status;

    utf16_to_utf8_transcoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .final_byte   (final_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .empty        (empty),
        .pop          (pop),
        .utf8_byte    (utf8_byte),
        .byte_present (byte_present),
        .run_end      (run_end),
        .message_done (message_done),
        .status       (status)
    );

    always #CLK_HALF_NS clk = ~clk;

    // Bytes waiting to be sent, the message under construction, and the UTF-8
    // items that the transcoder still owes us, oldest first.
    utf16_octet_t pending_octets[$];
    logic [7:0]   msg_octets[$];
    utf8_item_t   owed_utf8[$];

    int mismatches = 0;
    int cycle_count = 0;

    // Our own copy of the transcoder state. The byte order mirrors the
    // register and is updated when its write transfer completes.
    logic       order_big = 1'b0;
    logic       half_held = 1'b0;
    logic [7:0] held_octet = 8'h00;
    logic       surr_waiting = 1'b0;
    logic [9:0] surr_bits = 10'h000;
    logic [2:0] msg_error = ST_OK;

    // Works out the UTF-8 items that one accepted byte causes and appends
    // them to the owed queue. The first error of a message sticks until the
    // final byte, and from then on only the final byte yields anything.
    task automatic predict_utf8(input logic [7:0] b, input logic fin);
        logic [15:0] unit;
        logic [20:0] cp;
        logic        have_cp;
        logic        is_high;
        logic        is_low;
        logic [7:0]  enc[4];
        int          nbytes;
        int          produced;
        utf8_item_t  item;
        have_cp = 1'b0;
        cp = '0;
        nbytes = 0;
        produced = 0;
        if (msg_error == ST_OK)
        begin
            if (!half_held)
            begin
                // The first byte of a unit; a final byte here means odd length.
                half_held = 1'b1;
                held_octet = b;
                if (fin)
                    msg_error = ST_ODD;
            end
            else
            begin
                unit = order_big ? {held_octet, b} : {b, held_octet};
                half_held = 1'b0;
                is_high = (unit[15:10] == 6'b110110);
                is_low  = (unit[15:10] == 6'b110111);
                if (surr_waiting)
                begin
                    // Whatever follows a high surrogate is consumed; only a
                    // low surrogate completes the pair.
                    surr_waiting = 1'b0;
                    if (is_low)
                    begin
                        have_cp = 1'b1;
                        cp = 21'h10000 + {1'b0, surr_bits, unit[9:0]};
                    end
                    else
                        msg_error = ST_BAD_PAIR;
                end
                else if (is_high)
                begin
                    surr_waiting = 1'b1;
                    surr_bits = unit[9:0];
                end
                else if (is_low)
                    msg_error = ST_LONE_LOW;
                else
                begin
                    have_cp = 1'b1;
                    cp = {5'd0, unit};
                end
                if (fin && msg_error == ST_OK && surr_waiting)
                    msg_error = ST_TRUNC_HIGH;
            end
        end

        if (have_cp)
        begin
            if (cp <= 21'h7F)
            begin
                nbytes = 1;
                enc[0] = {1'b0, cp[6:0]};
            end
            else if (cp <= 21'h7FF)
            begin
                nbytes = 2;
                enc[0] = 8'hC0 | {3'b000, cp[10:6]};
                enc[1] = 8'h80 | {2'b00, cp[5:0]};
            end
            else if (cp <= 21'hFFFF)
            begin
                nbytes = 3;
                enc[0] = 8'hE0 | {4'h0, cp[15:12]};
                enc[1] = 8'h80 | {2'b00, cp[11:6]};
                enc[2] = 8'h80 | {2'b00, cp[5:0]};
            end
            else
            begin
                nbytes = 4;
                enc[0] = 8'hF0 | {5'd0, cp[20:18]};
                enc[1] = 8'h80 | {2'b00, cp[17:12]};
                enc[2] = 8'h80 | {2'b00, cp[11:6]};
                enc[3] = 8'h80 | {2'b00, cp[5:0]};
            end
        end
        for (int k = 0; k < nbytes; k++)
        begin
            item = '{octet: enc[k], present: 1'b1, last_of_run: 1'b0, done: 1'b0, code: ST_OK};
            owed_utf8 = {owed_utf8, item};
            produced++;
        end

        if (fin)
        begin
            // The status item closes the message and the message state clears.
            item = '{octet: 8'h00, present: 1'b0, last_of_run: 1'b0, done: 1'b1,
                     code: msg_error};
            owed_utf8 = {owed_utf8, item};
            produced++;
            half_held = 1'b0;
            held_octet = 8'h00;
            surr_waiting = 1'b0;
            surr_bits = 10'h000;
            msg_error = ST_OK;
        end
        if (produced > 0)
            owed_utf8[owed_utf8.size() - 1].last_of_run = 1'b1;
    endtask

    // Appends one code unit to the message being built, in the current byte order.
    task automatic append_unit(input logic [15:0] unit);
        if (order_big)
        begin
            msg_octets = {msg_octets, unit[15:8]};
            msg_octets = {msg_octets, unit[7:0]};
        end
        else
        begin
            msg_octets = {msg_octets, unit[7:0]};
            msg_octets = {msg_octets, unit[15:8]};
        end
    endtask

    // Hands the built message to the sender, flagging its last byte.
    task automatic flush_message();
        utf16_octet_t o;
        for (int i = 0; i < msg_octets.size(); i++)
        begin
            o.octet = msg_octets[i];
            o.last = (i == msg_octets.size() - 1);
            pending_octets = {pending_octets, o};
        end
        msg_octets.delete();
    endtask

    // Mostly well-formed messages with random content: ASCII, two and three
    // byte code points and surrogate pairs, salted with lone lows, broken
    // pairs, a dangling high surrogate at the end, stray odd bytes and raw noise.
    task automatic queue_random_messages(input int budget);
        int          queued;
        int          units;
        int          r;
        logic [15:0] u;
        logic [7:0]  stray;
        queued = 0;
        while (queued < budget)
        begin
            units = $urandom_range(1, 6);
            for (int i = 0; i < units; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    append_unit(16'($urandom_range(0, 16'h7F)));
                else if (r < 45)
                    append_unit(16'($urandom_range(16'h80, 16'h7FF)));
                else if (r < 65)
                begin
                    u = 16'($urandom_range(16'h800, 16'hFFFF));
                    // Keep it out of the surrogate range.
                    if (u[15:11] == 5'b11011)
                        u[15] = 1'b0;
                    append_unit(u);
                end
                else if (r < 85)
                begin
                    append_unit(16'hD800 | 16'($urandom_range(0, 1023)));
                    append_unit(16'hDC00 | 16'($urandom_range(0, 1023)));
                end
                else if (r < 90)
                    append_unit(16'hDC00 | 16'($urandom_range(0, 1023)));
                else if (r < 94)
                begin
                    append_unit(16'hD800 | 16'($urandom_range(0, 1023)));
                    append_unit(16'($urandom_range(0, 16'hDBFF)));
                end
                else
                    append_unit(16'($urandom_range(0, 16'hFFFF)));
            end
            r = $urandom_range(0, 99);
            if (r < 6)
                append_unit(16'hD800 | 16'($urandom_range(0, 1023)));
            else if (r < 12)
            begin
                stray = 8'($urandom_range(0, 255));
                msg_octets = {msg_octets, stray};
            end
            queued += msg_octets.size();
            flush_message();
        end
    endtask

    // Idle lengths for both sides: mostly none or short, a few long, and now
    // and then a stretch of back-to-back transfers.
    function automatic int draw_gap(inout int steady);
        int r;
        if (steady > 0)
        begin
            steady--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            steady = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    // Waits until every byte is sent and every owed item has arrived, then
    // lets the pipeline settle, since a byte that causes no result may
    // still be inside the block.
    task automatic wait_drained();
        while (pending_octets.size() != 0 || push || owed_utf8.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the byte order register over its own channel; only called idle.
    task automatic write_byte_order(input logic big);
        @(negedge clk);
        cfg_data <= big;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        order_big = big;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Input side. The sender holds a byte until its transfer, then waits a
    // random gap before offering the next one from the pending queue.
    // ------------------------------------------------------------------
    logic         push_took = 1'b0;
    int           send_gap = 0;
    int           send_steady = 0;
    utf16_octet_t next_octet;

    always @(posedge clk)
    begin
        push_took <= push && !full;
        if (rst_n && push && !full)
            predict_utf8(data_byte, final_byte);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (push && !push_took)
            ; // The offered byte has not been taken yet; keep it steady.
        else if (send_gap > 0)
        begin
            send_gap--;
            push <= 1'b0;
        end
        else if (pending_octets.size() > 0)
        begin
            next_octet = pending_octets.pop_front();
            data_byte <= next_octet.octet;
            final_byte <= next_octet.last;
            push <= 1'b1;
            send_gap = draw_gap(send_steady);
        end
        else
            push <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Output side. The receiver stalls at random; every transfer is
    // checked against the oldest owed item.
    // ------------------------------------------------------------------
    logic       pop_took = 1'b0;
    int         recv_stall = 0;
    int         recv_steady = 0;
    utf8_item_t got_item;
    utf8_item_t want_item;

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop_took)
                recv_stall = draw_gap(recv_steady);
            if (recv_stall > 0)
            begin
                recv_stall--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pop_took <= pop && !empty;
        if (rst_n && pop && !empty)
        begin
            got_item = '{octet: utf8_byte, present: byte_present, last_of_run: run_end,
                         done: message_done, code: status};
            if (owed_utf8.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected item: expected none, actual byte=%02h present=%0b",
                             $time, got_item.octet, got_item.present,
                             " run_end=%0b done=%0b status=%0d",
                             got_item.last_of_run, got_item.done, got_item.code);
            end
            else
            begin
                want_item = owed_utf8.pop_front();
                if (got_item !== want_item)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: item mismatch: expected byte=%02h present=%0b",
                                 $time, want_item.octet, want_item.present,
                                 " run_end=%0b done=%0b status=%0d,",
                                 want_item.last_of_run, want_item.done, want_item.code,
                                 " actual byte=%02h present=%0b run_end=%0b done=%0b",
                                 got_item.octet, got_item.present, got_item.last_of_run,
                                 got_item.done, " status=%0d", got_item.code);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence: reset, a directed set under the reset byte order, then
    // random phases under alternating byte orders, each register write
    // made only once the block has drained.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Code point boundaries: zero, the first two-byte value, the last
        // two-byte value, the last BMP value, and the lowest and highest
        // supplementary planes through surrogate pairs.
        append_unit(16'h0000);
        append_unit(16'h0080);
        append_unit(16'h07FF);
        append_unit(16'hFFFF);
        append_unit(16'hD800);
        append_unit(16'hDC00);
        append_unit(16'hDBFF);
        append_unit(16'hDFFF);
        flush_message();
        // A lone low surrogate; the odd trailing byte after it must not
        // override the first error, and yields only the status item.
        append_unit(16'hDC00);
        msg_octets = {msg_octets, 8'h41};
        flush_message();
        // A high surrogate followed by a plain character is a bad pair.
        append_unit(16'hD800);
        append_unit(16'h0041);
        flush_message();
        // A high surrogate at the end of the message is a truncated pair.
        append_unit(16'hD800);
        flush_message();
        queue_random_messages(60);
        wait_drained();

        write_byte_order(1'b1);
        queue_random_messages(65);
        wait_drained();

        write_byte_order(1'b0);
        queue_random_messages(65);
        wait_drained();

        write_byte_order(1'b1);
        queue_random_messages(65);
        wait_drained();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_job_fifo.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_transcoder.sv
dv/tb_utf16_to_utf8_transcoder.sv
